/* hdl/scfr_pkg.sv */
package scfr_pkg;

    localparam logic [7:0]  RSP_ACK      = 8'h41;
    localparam logic [7:0]  RSP_NACK     = 8'h4E;
    localparam logic [7:0]  RSP_DONE     = 8'h43;
    localparam logic [7:0]  CMD_REGWRITE = 8'h01;
    localparam logic [7:0]  CMD_PLAY     = 8'h02;
    localparam logic [7:0]  DEV_ID_RST   = 8'h73;
    localparam logic [15:0] TIMEOUT_RST  = 16'd5000;

    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_TICK   = 1'b1;
    localparam logic KIND_HOST = 1'b0;
    localparam logic KIND_REG  = 1'b1;

    localparam logic CFG_DEVICE_ID = 1'b0;
    localparam logic CFG_TIMEOUT   = 1'b1;

    // work handed from the frame decoder to the response generator
    typedef enum logic [1:0] {
        JOB_ACK,
        JOB_NACK,
        JOB_BURST
    } t_job;

    typedef struct packed {
        logic [7:0]  device_id;
        logic [15:0] timeout_ticks;
    } t_cfg;

    // 8-bit add with end-around carry
    function automatic logic [7:0] add_eac(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

endpackage

/* hdl/scfr_job_fifo.sv */
module scfr_job_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  scfr_pkg::t_job     i_job,
    output logic               o_full,
    input  logic               i_pop,
    output scfr_pkg::t_job     o_job,
    output logic               o_empty
);

    scfr_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           n_wp;
    logic           n_rp;
    logic [1:0]     n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

/* hdl/scfr_front.sv */
module scfr_front #(
    parameter int NUM_REGS = 25,
    parameter int IDX_W    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  scfr_pkg::t_cfg       i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_operation,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output scfr_pkg::t_job       o_q_job,
    input  logic                 i_burst_done,
    output logic                 o_buf_we,
    output logic [IDX_W-1:0]     o_buf_addr,
    output logic [7:0]           o_buf_data
);

    localparam int CNT_W = $clog2(NUM_REGS + 1);

    localparam logic [2:0] PH_ID      = 3'd0;
    localparam logic [2:0] PH_CMD     = 3'd1;
    localparam logic [2:0] PH_AUX1    = 3'd2;
    localparam logic [2:0] PH_AUX2    = 3'd3;
    localparam logic [2:0] PH_CKSUM   = 3'd4;
    localparam logic [2:0] PH_DATA    = 3'd5;
    localparam logic [2:0] PH_DISCARD = 3'd7;

    logic [2:0]       r_phase;
    logic [7:0]       r_cmd;
    logic [7:0]       r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_elapsed;
    logic             r_burst_out;
    logic [2:0]       n_phase;
    logic [7:0]       n_cmd;
    logic [7:0]       n_sum;
    logic [CNT_W-1:0] n_cnt;
    logic [15:0]      n_elapsed;
    logic             n_burst_out;

    logic             accept;
    logic             data_wr_phase;
    logic [15:0]      tick_cnt;

    assign data_wr_phase = (r_phase == PH_DATA) && (r_cnt < CNT_W'(NUM_REGS));
    // a data byte may not overwrite the buffer while a register burst still reads it
    assign o_in_ready = !i_q_full
                        && !(i_operation == scfr_pkg::OP_BYTE && data_wr_phase && r_burst_out);
    assign accept     = i_in_valid && o_in_ready;
    assign tick_cnt   = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign o_buf_addr = r_cnt[IDX_W-1:0];
    assign o_buf_data = i_rx_byte;

    always_comb begin
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_elapsed   = r_elapsed;
        n_burst_out = r_burst_out;
        o_q_push    = 1'b0;
        o_q_job     = scfr_pkg::JOB_ACK;
        o_buf_we    = 1'b0;

        if (accept) begin
            if (i_operation == scfr_pkg::OP_TICK) begin
                if (r_phase != PH_ID) begin
                    if (tick_cnt > i_cfg.timeout_ticks) begin
                        if (r_phase >= 3'd6) begin
                            n_phase   = PH_ID;
                            n_sum     = 8'd0;
                            n_cnt     = '0;
                            n_elapsed = 16'd0;
                        end else begin
                            n_phase   = PH_DISCARD;
                            n_elapsed = 16'd0;
                        end
                    end else begin
                        n_elapsed = tick_cnt;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_ID: begin
                        if (i_rx_byte == i_cfg.device_id) begin
                            n_sum     = i_rx_byte;
                            n_elapsed = 16'd0;
                            n_phase   = PH_CMD;
                        end else begin
                            n_phase   = PH_DISCARD;
                            n_elapsed = 16'd0;
                        end
                    end
                    PH_CMD: begin
                        n_cmd   = i_rx_byte;
                        n_sum   = scfr_pkg::add_eac(r_sum, i_rx_byte);
                        n_phase = PH_AUX1;
                    end
                    PH_AUX1: begin
                        n_sum   = scfr_pkg::add_eac(r_sum, i_rx_byte);
                        n_phase = PH_AUX2;
                    end
                    PH_AUX2: begin
                        n_sum   = scfr_pkg::add_eac(r_sum, i_rx_byte);
                        n_phase = PH_CKSUM;
                    end
                    PH_CKSUM: begin
                        if (i_rx_byte != r_sum) begin
                            n_phase   = PH_DISCARD;
                            n_elapsed = 16'd0;
                        end else begin
                            o_q_push = 1'b1;
                            o_q_job  = scfr_pkg::JOB_ACK;
                            if (r_cmd == scfr_pkg::CMD_REGWRITE) begin
                                n_phase   = PH_DATA;
                                n_sum     = 8'd0;
                                n_cnt     = '0;
                                n_elapsed = 16'd0;
                            end else if (r_cmd == scfr_pkg::CMD_PLAY) begin
                                n_phase   = PH_ID;
                                n_sum     = 8'd0;
                                n_cnt     = '0;
                                n_elapsed = 16'd0;
                            end else begin
                                n_phase   = PH_DISCARD;
                                n_elapsed = 16'd0;
                            end
                        end
                    end
                    PH_DATA: begin
                        if (data_wr_phase) begin
                            o_buf_we = 1'b1;
                            n_sum    = scfr_pkg::add_eac(r_sum, i_rx_byte);
                            n_cnt    = r_cnt + CNT_W'(1);
                        end else begin
                            o_q_push  = 1'b1;
                            o_q_job   = (i_rx_byte == r_sum) ? scfr_pkg::JOB_BURST
                                                             : scfr_pkg::JOB_NACK;
                            n_phase   = PH_ID;
                            n_sum     = 8'd0;
                            n_cnt     = '0;
                            n_elapsed = 16'd0;
                        end
                    end
                    default: begin
                        n_elapsed = 16'd0;
                    end
                endcase
            end
        end

        if (i_burst_done) begin
            n_burst_out = 1'b0;
        end
        if (o_q_push && o_q_job == scfr_pkg::JOB_BURST) begin
            n_burst_out = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ID;
            r_cmd       <= 8'd0;
            r_sum       <= 8'd0;
            r_cnt       <= '0;
            r_elapsed   <= 16'd0;
            r_burst_out <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cmd       <= n_cmd;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_elapsed   <= n_elapsed;
            r_burst_out <= n_burst_out;
        end
    end

endmodule

/* hdl/scfr_back.sv */
module scfr_back #(
    parameter int NUM_REGS = 25,
    parameter int IDX_W    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  scfr_pkg::t_job       i_q_job,
    output logic                 o_q_pop,
    input  logic                 i_buf_we,
    input  logic [IDX_W-1:0]     i_buf_addr,
    input  logic [7:0]           i_buf_data,
    output logic                 o_burst_done,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_out_kind,
    output logic [7:0]           o_out_value,
    output logic [4:0]           o_reg_index,
    output logic                 o_last
);

    // burst step counts register writes, then ACK, then COMPLETE
    localparam int STEP_W = $clog2(NUM_REGS + 2);

    logic [7:0]        r_buf [NUM_REGS];

    logic              r_busy;
    scfr_pkg::t_job    r_job;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic              r_out_kind;
    logic [7:0]        r_out_value;
    logic [4:0]        r_reg_index;
    logic              r_last;

    logic              n_busy;
    scfr_pkg::t_job    n_job;
    logic [STEP_W-1:0] n_step;
    logic              n_out_valid;
    logic              n_out_kind;
    logic [7:0]        n_out_value;
    logic [4:0]        n_reg_index;
    logic              n_last;

    logic              can_emit;
    logic [7:0]        rd_data;

    assign can_emit = !r_out_valid || i_out_ready;
    assign rd_data  = r_buf[r_step[IDX_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_buf_we) begin
            r_buf[i_buf_addr] <= i_buf_data;
        end
    end

    always_comb begin
        n_busy       = r_busy;
        n_job        = r_job;
        n_step       = r_step;
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_value  = r_out_value;
        n_reg_index  = r_reg_index;
        n_last       = r_last;
        o_q_pop      = 1'b0;
        o_burst_done = 1'b0;

        if (!r_busy && !i_q_empty) begin
            o_q_pop = 1'b1;
            n_busy  = 1'b1;
            n_job   = i_q_job;
            n_step  = '0;
        end

        if (can_emit) begin
            n_out_valid = 1'b0;
            if (r_busy) begin
                n_out_valid = 1'b1;
                n_out_kind  = scfr_pkg::KIND_HOST;
                n_reg_index = 5'd0;
                n_last      = 1'b1;
                unique case (r_job)
                    scfr_pkg::JOB_ACK: begin
                        n_out_value = scfr_pkg::RSP_ACK;
                        n_busy      = 1'b0;
                    end
                    scfr_pkg::JOB_NACK: begin
                        n_out_value = scfr_pkg::RSP_NACK;
                        n_busy      = 1'b0;
                    end
                    scfr_pkg::JOB_BURST: begin
                        if (r_step < STEP_W'(NUM_REGS)) begin
                            n_out_kind  = scfr_pkg::KIND_REG;
                            n_out_value = rd_data;
                            n_reg_index = 5'(r_step);
                            n_last      = 1'b0;
                            n_step      = r_step + STEP_W'(1);
                        end else if (r_step == STEP_W'(NUM_REGS)) begin
                            n_out_value = scfr_pkg::RSP_ACK;
                            n_last      = 1'b0;
                            n_step      = r_step + STEP_W'(1);
                        end else begin
                            n_out_value  = scfr_pkg::RSP_DONE;
                            n_busy       = 1'b0;
                            o_burst_done = 1'b1;
                        end
                    end
                    default: begin
                        n_out_valid = 1'b0;
                        n_busy      = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job       <= n_job;
        r_step      <= n_step;
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
        r_reg_index <= n_reg_index;
        r_last      <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_value = r_out_value;
    assign o_reg_index = r_reg_index;
    assign o_last      = r_last;

endmodule

/* hdl/sio_command_frame_receiver.sv */
// Channel    | Direction | Handshake                     | Payload
// in         | to block  | i_in_valid / o_in_ready       | i_operation, i_rx_byte
// out        | from block| o_out_valid / i_out_ready     | o_out_kind, o_out_value,
//            |           |                               | o_reg_index, o_last
// cfg        | to block  | i_cfg_we (no wait)            | i_cfg_index, i_cfg_data
//
// The decoder takes one byte or tick per cycle while the two-entry job queue has room.
// A good data frame checksum yields NUM_REGS + 2 results, one per cycle while the output
// is ready, once the generator has fetched the job; ACK or NACK alone pass through the job
// queue, the generator's job register and the output register, which sets the back end's pace.
// While a register burst is still being sent, data bytes of the next frame wait.
// Reset is synchronous and clears control state; the data buffer is not cleared.
module sio_command_frame_receiver #(
    parameter int NUM_REGS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_out_kind,
    output logic [7:0]  o_out_value,
    output logic [4:0]  o_reg_index,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    scfr_pkg::t_cfg   r_cfg;
    logic             q_push;
    scfr_pkg::t_job   q_in_job;
    logic             q_full;
    logic             q_pop;
    scfr_pkg::t_job   q_out_job;
    logic             q_empty;
    logic             burst_done;
    logic             buf_we;
    logic [IDX_W-1:0] buf_addr;
    logic [7:0]       buf_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_id     <= scfr_pkg::DEV_ID_RST;
            r_cfg.timeout_ticks <= scfr_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                scfr_pkg::CFG_DEVICE_ID: r_cfg.device_id     <= i_cfg_data[7:0];
                scfr_pkg::CFG_TIMEOUT:   r_cfg.timeout_ticks <= i_cfg_data;
                default:                 r_cfg               <= r_cfg;
            endcase
        end
    end

    scfr_front #(
        .NUM_REGS (NUM_REGS),
        .IDX_W    (IDX_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_rx_byte    (i_rx_byte),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_job      (q_in_job),
        .i_burst_done (burst_done),
        .o_buf_we     (buf_we),
        .o_buf_addr   (buf_addr),
        .o_buf_data   (buf_data)
    );

    scfr_job_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_empty (q_empty)
    );

    scfr_back #(
        .NUM_REGS (NUM_REGS),
        .IDX_W    (IDX_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_job      (q_out_job),
        .o_q_pop      (q_pop),
        .i_buf_we     (buf_we),
        .i_buf_addr   (buf_addr),
        .i_buf_data   (buf_data),
        .o_burst_done (burst_done),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_kind   (o_out_kind),
        .o_out_value  (o_out_value),
        .o_reg_index  (o_reg_index),
        .o_last       (o_last)
    );

endmodule

/* hdl/scfr_checker.sv */
module scfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_operation,
    input logic [7:0]  i_rx_byte,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_out_kind,
    input logic [7:0]  o_out_value,
    input logic [4:0]  o_reg_index,
    input logic        o_last,
    input logic        i_cfg_we,
    input logic        i_cfg_index,
    input logic [15:0] i_cfg_data
);

    // a stalled output transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_kind) && $stable(o_out_value)
            && $stable(o_reg_index) && $stable(o_last))
        else $error("output transaction changed while stalled");

    // register writes are never the final result of a byte
    a_reg_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == scfr_pkg::KIND_REG |-> !o_last)
        else $error("register write marked last");

    // host bytes are only A, N or C with a zero index
    a_host_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == scfr_pkg::KIND_HOST |->
            o_reg_index == 5'd0
            && (o_out_value == scfr_pkg::RSP_ACK || o_out_value == scfr_pkg::RSP_NACK
                || o_out_value == scfr_pkg::RSP_DONE))
        else $error("bad host response byte");

    // COMPLETE always follows an ACK transaction that is not marked last
    a_done_after_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_kind == scfr_pkg::KIND_HOST
        && o_out_value == scfr_pkg::RSP_ACK && !o_last |=>
            o_out_valid && o_out_kind == scfr_pkg::KIND_HOST
            && o_out_value == scfr_pkg::RSP_DONE && o_last)
        else $error("ACK inside burst not followed by COMPLETE");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind sio_command_frame_receiver scfr_checker u_scfr_checker (.*);
